/* sv/fpcc_pkg.sv */
package fpcc_pkg;

  localparam int HeaderBytes = 12;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPolyC = 32'h82F6_3B78;

  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusTooShort    = 3'd1,
    StatusBadMagic    = 3'd2,
    StatusLenMismatch = 3'd3,
    StatusCrcMismatch = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] header_crc;
    logic [31:0] computed_crc;
    logic [31:0] payload_length;
  } result_t;

  // Magic "DHUB", byte 0 first.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h44;
      2'd1:    b = 8'h48;
      2'd2:    b = 8'h55;
      2'd3:    b = 8'h42;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Reflected CRC32C, one byte.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyC) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* sv/fpcc_in_reg.sv */
module fpcc_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fpcc_pkg::in_item_t item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output fpcc_pkg::in_item_t item_o
);
  import fpcc_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;

  assign in_stall_o = valid_q && !advance_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/fpcc_frame_check.sv */
module fpcc_frame_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  fpcc_pkg::in_item_t item_i,
  output fpcc_pkg::result_t  result_o
);
  import fpcc_pkg::*;

  logic [31:0] count_q, count_d;
  logic        magic_q, magic_d;
  logic [31:0] hcrc_q, hcrc_d;
  logic [31:0] hlen_q, hlen_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] count_nx, hcrc_nx, hlen_nx, crc_nx, computed;
  logic        magic_nx;
  status_e     status;

  always_comb begin
    magic_nx = magic_q;
    hcrc_nx  = hcrc_q;
    hlen_nx  = hlen_q;
    crc_nx   = crc_q;
    if (count_q < 32'd4) begin
      if (item_i.data_byte != magic_byte(count_q[1:0])) begin
        magic_nx = 1'b0;
      end
    end else if (count_q < 32'd8) begin
      hcrc_nx = {hcrc_q[23:0], item_i.data_byte};
    end else if (count_q < 32'(HeaderBytes)) begin
      hlen_nx = {hlen_q[23:0], item_i.data_byte};
    end else begin
      crc_nx = crc32c_byte(crc_q, item_i.data_byte);
    end
    count_nx = (count_q == AllOnes) ? count_q : count_q + 32'd1;
    computed = crc_nx ^ AllOnes;

    if (count_nx < 32'(HeaderBytes)) begin
      status = StatusTooShort;
    end else if (!magic_nx) begin
      status = StatusBadMagic;
    end else if (count_nx == AllOnes ||
                 ({1'b0, hlen_nx} + 33'(HeaderBytes)) != {1'b0, count_nx}) begin
      status = StatusLenMismatch;
    end else if (hcrc_nx != 32'd0 && hcrc_nx != computed) begin
      status = StatusCrcMismatch;
    end else begin
      status = StatusOk;
    end

    count_d = count_q;
    magic_d = magic_q;
    hcrc_d  = hcrc_q;
    hlen_d  = hlen_q;
    crc_d   = crc_q;
    if (take_i) begin
      if (item_i.last_byte) begin
        // frame done: back to the idle values
        count_d = 32'd0;
        magic_d = 1'b1;
        hcrc_d  = 32'd0;
        hlen_d  = 32'd0;
        crc_d   = AllOnes;
      end else begin
        count_d = count_nx;
        magic_d = magic_nx;
        hcrc_d  = hcrc_nx;
        hlen_d  = hlen_nx;
        crc_d   = crc_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 32'd0;
      magic_q <= 1'b1;
      hcrc_q  <= 32'd0;
      hlen_q  <= 32'd0;
      crc_q   <= AllOnes;
    end else begin
      count_q <= count_d;
      magic_q <= magic_d;
      hcrc_q  <= hcrc_d;
      hlen_q  <= hlen_d;
      crc_q   <= crc_d;
    end
  end

  assign result_o.status         = status;
  assign result_o.header_crc     = hcrc_nx;
  assign result_o.computed_crc   = computed;
  assign result_o.payload_length = hlen_nx;

endmodule

/* sv/fpcc_out_reg.sv */
module fpcc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fpcc_pkg::result_t result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fpcc_pkg::result_t result_o
);
  import fpcc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // slot frees up when empty or when the held item leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (free_o) begin
      valid_d = load_i;
    end
    if (load_i) begin
      res_d = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

/* sv/framed_payload_crc32c_checker.sv */
// Framed payload checker: 12-byte header (magic "DHUB", big-endian CRC,
// big-endian payload length) followed by payload bytes, checked with a
// reflected CRC32C over the payload.
//
// Input channel: one byte per item (data_byte_i, last_byte_i), taken when
// in_valid_i is high and in_stall_o is low; one per cycle unless stalled.
// Output channel: one result item per frame, after the marked last byte:
// status_o, header_crc_o, computed_crc_o, payload_length_o, taken when
// out_valid_o is high and out_stall_i is low.
//
// Path: a last byte waits in the input register for a free result slot,
// then its result loads into the output register. The byte-wide CRC step,
// length compare and status priority sit between the two registers, so
// throughput is one byte per cycle while no last byte waits for the slot.
//
// Stall: a stalled result holds in the output register. Non-last bytes
// keep flowing while it waits; a second last byte parks in the input
// register and in_stall_o rises until the result slot frees.
// Reset: clears both valid flags and returns the frame state to its idle
// values (count 0, magic good, CRC all ones).
module framed_payload_crc32c_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] header_crc_o,
  output logic [31:0] computed_crc_o,
  output logic [31:0] payload_length_o
);
  import fpcc_pkg::*;

  in_item_t in_item, st_item;
  logic     st_valid, out_free, advance, take;
  result_t  st_result, out_result;

  assign in_item.data_byte = data_byte_i;
  assign in_item.last_byte = last_byte_i;

  // Only a last byte needs the result slot; others always move on.
  assign advance = !st_item.last_byte || out_free;
  assign take    = st_valid && advance;

  fpcc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (st_valid),
    .item_o     (st_item)
  );

  fpcc_frame_check u_frame_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (st_item),
    .result_o (st_result)
  );

  fpcc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && st_item.last_byte),
    .result_i    (st_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign status_o         = out_result.status;
  assign header_crc_o     = out_result.header_crc;
  assign computed_crc_o   = out_result.computed_crc;
  assign payload_length_o = out_result.payload_length;

endmodule

/* sv/fpcc_checker.sv */
module fpcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] header_crc_o,
  input logic [31:0] computed_crc_o
);
  import fpcc_pkg::*;

  // held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(computed_crc_o))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StatusCrcMismatch)
    else $error("status code out of range");

  // a short frame never reaches the payload
  a_short_no_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusTooShort |-> computed_crc_o == 32'd0)
    else $error("short frame with payload CRC");

  a_ok_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusOk |->
      header_crc_o == 32'd0 || header_crc_o == computed_crc_o)
    else $error("ok status with CRC mismatch");

endmodule

bind framed_payload_crc32c_checker fpcc_checker u_fpcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .header_crc_o   (header_crc_o),
  .computed_crc_o (computed_crc_o)
);

/* test/frame_result_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the frame checker, predicts one status item per
// frame and compares it with what comes out.
module frame_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] header_crc_i,
  input  logic [31:0] computed_crc_i,
  input  logic [31:0] payload_length_i,
  output int          errors_o,
  output int          frames_open_o
);
  import fpcc_pkg::*;

  localparam logic [31:0] FrameMagic = "DHUB";
  localparam logic [31:0] Crc32cPoly = 32'h82F6_3B78;

  // Frame state as seen so far
  logic [31:0] seen_bytes;
  logic        magic_ok;
  logic [31:0] hdr_crc;
  logic [31:0] hdr_len;
  logic [31:0] crc_acc;

  result_t frame_status_q[$];

  // LSB-first CRC32C, one bit per pass
  function automatic logic [31:0] crc32c_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ Crc32cPoly;
    end
    return r;
  endfunction

  task automatic clear_frame();
    seen_bytes = '0;
    magic_ok   = 1'b1;
    hdr_crc    = '0;
    hdr_len    = '0;
    crc_acc    = '1;
  endtask

  task automatic note_mismatch(input string msg);
    errors_o++;
    if (errors_o <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : watch
    result_t     want;
    logic [31:0] digest;
    status_e     st;

    if (!rst_ni) begin
      clear_frame();
      frame_status_q.delete();
      errors_o      = 0;
      frames_open_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (seen_bytes < 4) begin
          if (data_byte_i != FrameMagic[8 * (3 - seen_bytes[1:0]) +: 8]) magic_ok = 1'b0;
        end else if (seen_bytes < 8) begin
          hdr_crc = {hdr_crc[23:0], data_byte_i};
        end else if (seen_bytes < HeaderBytes) begin
          hdr_len = {hdr_len[23:0], data_byte_i};
        end else begin
          crc_acc = crc32c_step(crc_acc, data_byte_i);
        end
        if (seen_bytes != '1) seen_bytes++;

        if (last_byte_i) begin
          digest = ~crc_acc;
          if (seen_bytes < HeaderBytes) begin
            st = StatusTooShort;
          end else if (!magic_ok) begin
            st = StatusBadMagic;
          end else if (seen_bytes == '1 ||
                       {1'b0, hdr_len} + 33'(HeaderBytes) != {1'b0, seen_bytes}) begin
            st = StatusLenMismatch;
          end else if (hdr_crc != '0 && hdr_crc != digest) begin
            st = StatusCrcMismatch;
          end else begin
            st = StatusOk;
          end
          want.status         = st;
          want.header_crc     = hdr_crc;
          want.computed_crc   = digest;
          want.payload_length = hdr_len;
          frame_status_q.push_back(want);
          clear_frame();
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (frame_status_q.size() == 0) begin
          note_mismatch($sformatf("status item with no frame pending (status %0d)", status_i));
        end else begin
          want = frame_status_q.pop_front();
          if (status_i != want.status || header_crc_i != want.header_crc ||
              computed_crc_i != want.computed_crc ||
              payload_length_i != want.payload_length) begin
            note_mismatch($sformatf(
              "status %0d/%0d hdr_crc %08h/%08h crc %08h/%08h len %08h/%08h (exp/got)",
              want.status, status_i, want.header_crc, header_crc_i,
              want.computed_crc, computed_crc_i, want.payload_length, payload_length_i));
          end
        end
      end
      frames_open_o = frame_status_q.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the framed payload checker. Frame checks live in
// frame_result_checker, which sits beside the DUT on the same wires.
module tb_top;
  import fpcc_pkg::*;

  localparam logic [31:0] FrameMagic = "DHUB";
  localparam int          ByteTarget = 1450;

  // How the header CRC field of a generated frame is filled
  typedef enum logic [1:0] {
    CrcGood,
    CrcZero,
    CrcBad
  } crc_pick_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [31:0] header_crc_o;
  logic [31:0] computed_crc_o;
  logic [31:0] payload_length_o;

  int mismatches;
  int frames_open;

  // Frame under construction, byte 0 first
  logic [7:0] frame_bytes[$];
  int         bytes_sent;
  // While set, neither side idles nor stalls
  logic       quiet;

  framed_payload_crc32c_checker DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .header_crc_o    (header_crc_o),
    .computed_crc_o  (computed_crc_o),
    .payload_length_o(payload_length_o)
  );

  frame_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .header_crc_i    (header_crc_o),
    .computed_crc_i  (computed_crc_o),
    .payload_length_i(payload_length_o),
    .errors_o        (mismatches),
    .frames_open_o   (frames_open)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit: far beyond the slowest legal run of ~1.5k bytes with
  // 15% idle on both sides.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side: random stalls, none while quiet is set.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 15);
    end
  end

  // Header (magic, CRC, length, all big-endian) followed by pay_len random
  // payload bytes. The CRC for a good frame is taken from the package
  // helper; the checker predicts with its own.
  task automatic make_frame(input logic [31:0] magic, input crc_pick_e pick,
                            input logic [31:0] len_field, input int pay_len);
    logic [7:0]  body[$];
    logic [31:0] acc;
    logic [31:0] crc_field;
    acc = AllOnes;
    for (int i = 0; i < pay_len; i++) begin
      body.push_back(8'($urandom));
      acc = crc32c_byte(acc, body[i]);
    end
    case (pick)
      CrcGood: crc_field = ~acc;
      CrcZero: crc_field = '0;
      default: crc_field = $urandom;
    endcase
    frame_bytes.delete();
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(magic[8 * k +: 8]);
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(crc_field[8 * k +: 8]);
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(len_field[8 * k +: 8]);
    foreach (body[i]) frame_bytes.push_back(body[i]);
  endtask

  // Cut the current frame down to n bytes
  task automatic cut_frame(input int n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endtask

  // One item per byte; last_byte_i marks the final one. Valid is decided
  // before the handshake and held until the item is taken.
  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      while (!quiet && $urandom_range(0, 99) < 15) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= frame_bytes[i];
      last_byte_i <= (i == frame_bytes.size() - 1);
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    bytes_sent += frame_bytes.size();
  endtask

  initial begin
    int          frame_no;
    int          pay;
    int          roll;
    logic [31:0] len_field;
    logic [31:0] magic;
    crc_pick_e   pick;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    quiet       = 1'b0;
    bytes_sent  = 0;
    frame_no    = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed frames ---
    // one-byte frame: too short, header fields empty
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    // frame ends inside the CRC field: partial big-endian CRC reported
    make_frame(FrameMagic, CrcBad, 32'h0, 0);
    cut_frame(6);
    send_frame();
    // bare header, zero CRC, zero length: ok with empty payload
    make_frame(FrameMagic, CrcZero, 32'h0, 0);
    send_frame();
    // all-ones length with one payload byte; sum does not wrap to a match
    make_frame(FrameMagic, CrcGood, 32'hFFFF_FFFF, 1);
    frame_bytes[12] = 8'hFF;
    send_frame();

    // --- random frames ---
    while (bytes_sent < ByteTarget) begin
      // no idling on either side for a stretch of frames
      quiet = (frame_no >= 15 && frame_no < 27);
      pay   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 160) : $urandom_range(0, 24);
      roll  = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0, 1:    pick = CrcGood;
        2:       pick = CrcZero;
        default: pick = CrcBad;
      endcase

      if (roll < 55) begin
        // well-formed frame, CRC good, absent or wrong
        make_frame(FrameMagic, pick, pay, pay);
      end else if (roll < 65) begin
        // one magic byte corrupted, length sometimes wrong as well
        magic     = FrameMagic ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
        len_field = $urandom_range(0, 1) ? 32'(pay) : 32'($urandom);
        make_frame(magic, pick, len_field, pay);
      end else if (roll < 77) begin
        // length field off by a little, random, or near the top of the range
        case ($urandom_range(0, 3))
          0:       len_field = 32'(pay) + 32'($urandom_range(1, 3));
          1:       len_field = 32'(pay) - 32'd1;
          2:       len_field = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
          default: len_field = $urandom;
        endcase
        make_frame(FrameMagic, pick, len_field, pay);
      end else if (roll < 85) begin
        // frame ends inside the header
        make_frame(FrameMagic, pick, $urandom, 0);
        cut_frame($urandom_range(1, 11));
      end else begin
        // noise
        frame_bytes.delete();
        repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
      frame_no++;
    end

    quiet = 1'b0;
    in_valid_i <= 1'b0;

    // drain: wait until every frame is answered, then watch for strays
    @(negedge clk_i);
    while (frames_open != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
